/* sv/go_back_n_sender_top_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef GO_BACK_N_SENDER_TOP_MACROS_SVH
`define GO_BACK_N_SENDER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GBN_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbn check failed");
// Implication whose consequence is checked in the next cycle.
`define GBN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbn check failed");
`endif

/* sv/gbn_pkg.sv */
// Package with the command, result and register codes of the go-back-N sender.
package gbn_pkg;
	localparam logic [1:0] CMD_DATA  = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_ABORT = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	localparam logic [2:0] KIND_DATA  = 3'd0;
	localparam logic [2:0] KIND_CONF  = 3'd1;
	localparam logic [2:0] KIND_ABORT = 3'd2;
	localparam logic [2:0] KIND_BREAK = 3'd3;
	localparam logic [2:0] KIND_DISC  = 3'd4;

	localparam logic [1:0] REG_CONNECT = 2'd0;
	localparam logic [1:0] REG_RETX    = 2'd1;
	localparam logic [1:0] REG_INACT   = 2'd2;

	localparam logic [15:0] CONNECT_RESET = 16'd5;
	localparam logic [15:0] RETX_RESET    = 16'd5;
	localparam logic [15:0] INACT_RESET   = 16'd10;

	// One held frame: sequence, header fields and payload.
	typedef struct packed {
		logic [15:0] seq;
		logic [15:0] conn;
		logic        eom;
		logic [9:0]  len;
		logic [15:0] src;
		logic [15:0] dest;
		logic [31:0] payload;
	} frame_t;

	// Control from the sequencer to the timer unit.
	typedef struct packed {
		logic       tick;
		logic [2:0] arm;
		logic [2:0] disarm;
		logic       clear;
	} tmr_ctl_t;
endpackage

/* sv/gbn_timers.sv */
// Three tick timers served by one shared increment and compare unit.
module gbn_timers (
	input  logic             clk,
	input  logic             arst_n,
	input  gbn_pkg::tmr_ctl_t ctl,
	input  logic [15:0]      lim_connect,
	input  logic [15:0]      lim_retx,
	input  logic [15:0]      lim_inact,
	output logic             busy,
	output logic [2:0]       fired
);
	import gbn_pkg::*;

	logic [15:0] count_q [3];
	logic [2:0]  armed_q;
	logic [2:0]  fired_q;
	logic [1:0]  idx_q;
	logic        run_q;
	logic [15:0] cur;
	logic [15:0] nxt;
	logic [15:0] lim;

	always_comb begin
		cur = count_q[idx_q];
		nxt = (cur == 16'hFFFF) ? cur : cur + 16'd1;
		unique case (idx_q)
			2'd0:    lim = lim_connect;
			2'd1:    lim = lim_retx;
			default: lim = lim_inact;
		endcase
	end

	// A pending tick request already counts as busy, so the sequencer never
	// reads the fired flags before the pass over the timers has started.
	assign busy  = run_q || ctl.tick;
	assign fired = fired_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			fired_q <= '0;
			idx_q   <= '0;
			run_q   <= 1'b0;
			for (int t = 0; t < 3; t++) count_q[t] <= '0;
		end else if (ctl.clear) begin
			armed_q <= '0;
			run_q   <= 1'b0;
			for (int t = 0; t < 3; t++) count_q[t] <= '0;
		end else if (ctl.tick) begin
			run_q   <= 1'b1;
			idx_q   <= '0;
			fired_q <= '0;
		end else if (run_q) begin
			if (armed_q[idx_q]) begin
				count_q[idx_q] <= nxt;
				if (nxt >= lim) begin
					fired_q[idx_q] <= 1'b1;
					armed_q[idx_q] <= 1'b0;
				end
			end
			if (idx_q == 2'd2) run_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end else begin
			for (int t = 0; t < 3; t++) begin
				if (ctl.arm[t]) begin
					count_q[t] <= '0;
					armed_q[t] <= 1'b1;
				end else if (ctl.disarm[t]) begin
					armed_q[t] <= 1'b0;
				end
			end
		end
	end
endmodule

/* sv/go_back_n_sender_top.sv */
// Top level of the go-back-N sender: sequencer, window store and registers.
// The block takes one transaction on the input channel (command plus request
// fields) and answers with zero to WINDOW result transactions on the output
// channel; the last result of a command carries last_of_run.
// It works on one item at a time: in_stall stays high from acceptance until
// the last result of the command has been loaded into the output register.
// A tick stalls the input through dispatch, a wait while the shared increment
// and compare unit walks the three timers, and a decision, then through one
// result for an abort or a resend step and a result per resent frame.
// An ack walks the window one slot a cycle for the search and compaction
// together, and the input stays stalled throughout.
// A data request stalls the input through dispatch and one or two results;
// an ignored command only through dispatch.
// Each result stays in the output register until out_stall is low; the
// sequencer waits meanwhile, so a stalling receiver holds the block.
// Reset puts the sender idle with an empty window, timers disarmed and
// registers at 5, 5 and 10 ticks. Configuration is written over the APB
// port at byte addresses 0, 4 and 8 while the block is idle (user-enforced).
module go_back_n_sender_top #(
	parameter int WINDOW = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] seq_num,
	input  logic        end_of_message,
	input  logic [15:0] conn_id,
	input  logic [15:0] dest_address,
	input  logic [15:0] src_address,
	input  logic [9:0]  payload_len,
	input  logic [31:0] payload_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [15:0] out_seq,
	output logic        out_eom,
	output logic [15:0] out_conn,
	output logic [15:0] out_dest,
	output logic [15:0] out_src,
	output logic [9:0]  out_len,
	output logic [31:0] out_payload,
	output logic        last_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gbn_pkg::*;

	localparam int IW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_TICKWAIT, S_TICKDEC, S_RESEND, S_SEARCH,
		S_SHIFT, S_ACKEND, S_DATA2, S_EMIT
	} state_t;

	typedef enum logic [1:0] {M_IDLE, M_AWAIT, M_CONN, M_BREAK} mode_t;

	state_t      state_q;
	state_t      after_q;
	mode_t       mode_q;
	logic        cfb_q;
	logic [CW-1:0] count_q;
	frame_t      win_q [WINDOW];
	logic [15:0] final_q;
	logic [15:0] cur_conn_q;
	logic [15:0] lim_q [3];
	frame_t      in_q;
	logic [1:0]  cmd_q;
	logic [IW-1:0] ptr_q;
	logic        found_q;
	logic [15:0] newest_q;
	logic        pend_last_q;
	logic [2:0]  pend_kind_q;
	frame_t      pend_q_f;
	logic        ov_q;
	logic [2:0]  kind_q;
	frame_t      of_q;
	logic        last_q;
	tmr_ctl_t    tctl;
	logic        tbusy;
	logic [2:0]  fired;
	logic [IW-1:0] nxt_ptr;
	logic        out_free;
	logic        wr_en;
	logic [1:0]  widx;

	gbn_timers u_timers (
		.clk(clk), .arst_n(arst_n), .ctl(tctl),
		.lim_connect(lim_q[0]), .lim_retx(lim_q[1]), .lim_inact(lim_q[2]),
		.busy(tbusy), .fired(fired)
	);

	// Register file access.
	assign pready = 1'b1;
	assign widx   = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	always_comb begin
		unique case (widx)
			REG_CONNECT: prdata = {16'd0, lim_q[0]};
			REG_RETX:    prdata = {16'd0, lim_q[1]};
			REG_INACT:   prdata = {16'd0, lim_q[2]};
			default:     prdata = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !ov_q || !out_stall;
	assign nxt_ptr  = ptr_q + IW'(1);

	assign out_valid   = ov_q;
	assign kind        = kind_q;
	assign out_seq     = of_q.seq;
	assign out_eom     = of_q.eom;
	assign out_conn    = of_q.conn;
	assign out_dest    = of_q.dest;
	assign out_src     = of_q.src;
	assign out_len     = of_q.len;
	assign out_payload = of_q.payload;
	assign last_of_run = last_q;

	// Result that carries only a connection number (confirm carries seq too).
	function automatic frame_t ctl_frame(input logic [15:0] s, input logic [15:0] c);
		frame_t f;
		f = '0;
		f.seq = s;
		f.conn = c;
		return f;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q[0] <= CONNECT_RESET;
			lim_q[1] <= RETX_RESET;
			lim_q[2] <= INACT_RESET;
		end else if (wr_en) begin
			unique case (widx)
				REG_CONNECT: lim_q[0] <= pwdata[15:0];
				REG_RETX:    lim_q[1] <= pwdata[15:0];
				REG_INACT:   lim_q[2] <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		tmr_ctl_t tn;
		if (!arst_n) begin
			state_q     <= S_IDLE;
			after_q     <= S_IDLE;
			mode_q      <= M_IDLE;
			cfb_q       <= 1'b0;
			count_q     <= '0;
			final_q     <= '0;
			cur_conn_q  <= '0;
			ov_q        <= 1'b0;
			found_q     <= 1'b0;
			ptr_q       <= '0;
			tctl        <= '0;
			cmd_q       <= CMD_DATA;
		end else begin
			// Timer requests are one-cycle pulses built up during the cycle.
			tn = '0;
			if (ov_q && !out_stall && state_q != S_EMIT) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						in_q  <= '{seq: seq_num, conn: conn_id, eom: end_of_message,
							len: payload_len, src: src_address, dest: dest_address,
							payload: payload_word};
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (cmd_q == CMD_TICK) begin
						tn.tick = 1'b1;
						state_q <= S_TICKWAIT;
					end else if (mode_q == M_IDLE) begin
						if (cmd_q == CMD_DATA) begin
							cur_conn_q  <= in_q.conn;
							pend_kind_q <= KIND_DATA;
							pend_q_f    <= in_q;
							pend_last_q <= 1'b1;
							tn.arm      = 3'b001;
							mode_q      <= M_AWAIT;
							after_q     <= S_IDLE;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (mode_q == M_AWAIT) begin
						if (cmd_q == CMD_ACK) begin
							// Any ack stops the connect timer.
							tn.arm      = (in_q.seq == 16'd1) ? 3'b110 : 3'b000;
							tn.disarm   = 3'b001;
							cur_conn_q  <= in_q.conn;
							if (in_q.seq == 16'd1) begin
								pend_kind_q <= KIND_CONF;
								pend_q_f    <= ctl_frame(in_q.seq, in_q.conn);
								pend_last_q <= 1'b1;
								mode_q      <= M_CONN;
								after_q     <= S_IDLE;
								state_q     <= S_EMIT;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end else if (cmd_q == CMD_ABORT) begin
						tn.clear    = 1'b1;
						mode_q <= M_IDLE; count_q <= '0; final_q <= '0; cfb_q <= 1'b0;
						pend_kind_q <= KIND_ABORT;
						pend_q_f    <= ctl_frame(16'd0, in_q.conn);
						pend_last_q <= 1'b1;
						after_q     <= S_IDLE;
						state_q     <= S_EMIT;
					end else if (cmd_q == CMD_ACK) begin
						tn.arm   = (mode_q == M_BREAK) ? 3'b110 : 3'b010;
						newest_q <= win_q[count_q == '0 ? '0 : IW'(count_q - CW'(1))].seq;
						ptr_q    <= '0;
						found_q  <= 1'b0;
						state_q  <= S_SEARCH;
					end else if (mode_q == M_CONN) begin
						cur_conn_q  <= in_q.conn;
						pend_kind_q <= KIND_DATA;
						pend_q_f    <= in_q;
						pend_last_q <= 1'b0;
						if (count_q < CW'(WINDOW)) begin
							win_q[IW'(count_q)] <= in_q;
							count_q <= count_q + CW'(1);
						end
						if (in_q.eom) final_q <= in_q.seq;
						after_q <= S_DATA2;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DATA2: begin
					pend_last_q <= 1'b1;
					if (count_q >= CW'(WINDOW)) begin
						mode_q      <= M_BREAK;
						tn.arm      = 3'b110;
						pend_kind_q <= KIND_BREAK;
						pend_q_f    <= ctl_frame(16'd0, in_q.conn);
					end else begin
						tn.arm      = 3'b100;
						pend_kind_q <= KIND_CONF;
						pend_q_f    <= ctl_frame(in_q.seq, in_q.conn);
					end
					after_q <= S_IDLE;
					state_q <= S_EMIT;
				end
				S_TICKWAIT: begin
					if (!tbusy) state_q <= S_TICKDEC;
				end
				S_TICKDEC: begin
					if ((mode_q == M_AWAIT && fired[0]) ||
						((mode_q == M_CONN || mode_q == M_BREAK) && fired[2])) begin
						tn.clear    = 1'b1;
						pend_kind_q <= KIND_ABORT;
						pend_q_f    <= ctl_frame(16'd0, cur_conn_q);
						pend_last_q <= 1'b1;
						mode_q <= M_IDLE; count_q <= '0; final_q <= '0; cfb_q <= 1'b0;
						after_q <= S_IDLE;
						state_q <= S_EMIT;
					end else if ((mode_q == M_CONN || mode_q == M_BREAK) && fired[1]) begin
						cfb_q    <= (mode_q == M_BREAK);
						tn.arm   = 3'b010;
						ptr_q    <= '0;
						state_q  <= (count_q != '0) ? S_RESEND : S_IDLE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RESEND: begin
					pend_kind_q <= KIND_DATA;
					pend_q_f    <= win_q[ptr_q];
					pend_last_q <= (CW'(ptr_q) + CW'(1) >= count_q);
					ptr_q       <= nxt_ptr;
					after_q     <= (CW'(ptr_q) + CW'(1) >= count_q) ? S_IDLE : S_RESEND;
					state_q     <= S_EMIT;
				end
				S_SEARCH: begin
					if (CW'(ptr_q) >= count_q) begin
						state_q <= S_ACKEND;
					end else if (win_q[ptr_q].seq == in_q.seq) begin
						found_q <= 1'b1;
						state_q <= S_SHIFT;
					end else if (CW'(ptr_q) + CW'(1) >= count_q) begin
						state_q <= S_ACKEND;
					end else begin
						ptr_q <= nxt_ptr;
					end
				end
				S_SHIFT: begin
					if (CW'(ptr_q) + CW'(1) < count_q) begin
						win_q[ptr_q] <= win_q[nxt_ptr];
						ptr_q <= nxt_ptr;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_ACKEND;
					end
				end
				S_ACKEND: begin
					if (mode_q == M_CONN && in_q.seq == final_q) begin
						tn.clear    = 1'b1;
						pend_kind_q <= KIND_DISC;
						pend_q_f    <= ctl_frame(16'd0, in_q.conn);
						pend_last_q <= 1'b1;
						mode_q <= M_IDLE; count_q <= '0; final_q <= '0; cfb_q <= 1'b0;
						after_q <= S_IDLE;
						state_q <= S_EMIT;
					end else if (mode_q == M_BREAK && found_q && in_q.seq == newest_q) begin
						pend_kind_q <= KIND_CONF;
						pend_q_f    <= ctl_frame(in_q.seq, in_q.conn);
						pend_last_q <= 1'b1;
						mode_q      <= M_CONN;
						cfb_q       <= 1'b0;
						after_q     <= S_IDLE;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						kind_q  <= pend_kind_q;
						of_q    <= pend_q_f;
						last_q  <= pend_last_q;
						state_q <= after_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			tctl <= tn;
		end
	end
endmodule

/* sv/gbn_checker.sv */
// Port-level checker for the go-back-N sender, bound to the top level.
`include "go_back_n_sender_top_macros.svh"
module gbn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  kind,
	input logic [15:0] out_seq,
	input logic        last_of_run
);
	import gbn_pkg::*;

	`GBN_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`GBN_ASSERT_IMPL(a_kind_legal, out_valid, kind <= KIND_DISC)
	`GBN_ASSERT_IMPL(a_break_is_last, out_valid && kind == KIND_BREAK, last_of_run)
	`GBN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_seq))
endmodule

bind go_back_n_sender_top gbn_checker u_gbn_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
	.out_seq(out_seq), .last_of_run(last_of_run)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the go-back-N sender: directed table, random protocol traffic.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gbn_pkg::*;

	localparam int WIN        = 5;
	localparam int IDLE_LIMIT = 4000;   // cycles with no transaction before the run is declared hung
	localparam int DRAIN_WAIT = 2 * WIN + 20;
	localparam int HOLD_LEN   = 300;    // length of the long receiver hold-off

	// Protocol modes of the sender, as tracked by the predictor.
	typedef enum logic [1:0] {MODE_IDLE, MODE_AWAIT, MODE_CONN, MODE_BREAK} sender_mode_e;

	// One command on the input channel.
	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] seq;
		logic        eom;
		logic [15:0] conn;
		logic [15:0] dest;
		logic [15:0] src;
		logic [9:0]  len;
		logic [31:0] pay;
	} command_t;

	// One result transaction on the output channel.
	typedef struct {
		logic [2:0]  kind;
		logic [15:0] seq;
		logic        eom;
		logic [15:0] conn;
		logic [15:0] dest;
		logic [15:0] src;
		logic [9:0]  len;
		logic [31:0] pay;
		logic        last;
	} indication_t;

	// A directed row: the command and, where it is obvious, how many results it
	// must give and the kind of the first one (count -1 leaves it to the predictor).
	typedef struct {
		command_t   c;
		int         n_typed;
		logic [2:0] kind_typed;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = CMD_TICK;
	logic [15:0] seq_num = '0;
	logic        end_of_message = 1'b0;
	logic [15:0] conn_id = '0;
	logic [15:0] dest_address = '0;
	logic [15:0] src_address = '0;
	logic [9:0]  payload_len = '0;
	logic [31:0] payload_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [15:0] out_seq;
	logic        out_eom;
	logic [15:0] out_conn;
	logic [15:0] out_dest;
	logic [15:0] out_src;
	logic [9:0]  out_len;
	logic [31:0] out_payload;
	logic        last_of_run;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	go_back_n_sender_top #(.WINDOW(WIN)) dut (.*);

	// The clock runs with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: a private copy of the sender.
	sender_mode_e mode_q;
	frame_t       window_q [WIN];
	int           window_n;
	logic [15:0]  final_seq_q;
	logic [15:0]  conn_q;
	logic [15:0]  timer_cnt [3];
	logic [2:0]   timer_on;
	logic [15:0]  timeout_reg [3];

	indication_t expected_results [$];
	indication_t burst [$];

	int errors = 0;
	int commands_sent = 0;
	int results_seen = 0;
	int frames_seen = 0;
	int aborts_seen = 0;
	int disc_seen = 0;
	int breaks_seen = 0;
	logic [15:0] next_seq = 16'd2;
	bit hold_request = 1'b0;

	function automatic void sender_reset();
		mode_q = MODE_IDLE;
		window_n = 0;
		final_seq_q = '0;
		conn_q = '0;
		timer_on = '0;
		for (int t = 0; t < 3; t++) timer_cnt[t] = '0;
		timeout_reg[REG_CONNECT] = CONNECT_RESET;
		timeout_reg[REG_RETX] = RETX_RESET;
		timeout_reg[REG_INACT] = INACT_RESET;
	endfunction

	// Abort and disconnect both drop the connection and everything it held.
	function automatic void drop_connection();
		mode_q = MODE_IDLE;
		window_n = 0;
		final_seq_q = '0;
		timer_on = '0;
		for (int t = 0; t < 3; t++) timer_cnt[t] = '0;
	endfunction

	function automatic void start_timer(int t);
		timer_cnt[t] = '0;
		timer_on[t] = 1'b1;
	endfunction

	function automatic logic [2:0] advance_timers();
		logic [2:0] fired;
		fired = '0;
		for (int t = 0; t < 3; t++) begin
			if (timer_on[t]) begin
				if (timer_cnt[t] != 16'hFFFF) timer_cnt[t]++;
				if (timer_cnt[t] >= timeout_reg[t]) begin
					fired[t] = 1'b1;
					timer_on[t] = 1'b0;
				end
			end
		end
		return fired;
	endfunction

	function automatic void emit(logic [2:0] k, logic [15:0] s, logic e, logic [15:0] c,
			logic [15:0] d, logic [15:0] sr, logic [9:0] l, logic [31:0] p);
		indication_t r;
		r.kind = k; r.seq = s; r.eom = e; r.conn = c;
		r.dest = d; r.src = sr; r.len = l; r.pay = p; r.last = 1'b0;
		burst.push_back(r);
	endfunction

	// Drops the oldest held frame with this sequence; returns its slot or -1.
	function automatic int release_frame(logic [15:0] s);
		for (int i = 0; i < window_n; i++) begin
			if (window_q[i].seq == s) begin
				for (int j = i; j + 1 < window_n; j++) window_q[j] = window_q[j + 1];
				window_n--;
				return i;
			end
		end
		return -1;
	endfunction

	// Works out the results of one accepted command and queues them.
	function automatic void predict_sender(input command_t c, output int n, output logic [2:0] k0);
		logic [2:0]  fired;
		logic [15:0] newest;
		burst.delete();
		if (c.cmd == CMD_TICK) begin
			fired = advance_timers();
			// Connect or inactivity expiry beats a retransmit on the same tick.
			if (mode_q == MODE_AWAIT && fired[REG_CONNECT]) begin
				emit(KIND_ABORT, 0, 0, conn_q, 0, 0, 0, 0);
				drop_connection();
			end else if ((mode_q == MODE_CONN || mode_q == MODE_BREAK) && fired[REG_INACT]) begin
				emit(KIND_ABORT, 0, 0, conn_q, 0, 0, 0, 0);
				drop_connection();
			end else if ((mode_q == MODE_CONN || mode_q == MODE_BREAK) && fired[REG_RETX]) begin
				for (int i = 0; i < window_n; i++)
					emit(KIND_DATA, window_q[i].seq, window_q[i].eom, window_q[i].conn,
						window_q[i].dest, window_q[i].src, window_q[i].len,
						window_q[i].payload);
				start_timer(REG_RETX);
			end
		end else if (mode_q == MODE_IDLE) begin
			if (c.cmd == CMD_DATA) begin
				conn_q = c.conn;
				emit(KIND_DATA, c.seq, c.eom, c.conn, c.dest, c.src, c.len, c.pay);
				start_timer(REG_CONNECT);
				mode_q = MODE_AWAIT;
			end
		end else if (mode_q == MODE_AWAIT) begin
			if (c.cmd == CMD_ACK) begin
				timer_on[REG_CONNECT] = 1'b0;
				conn_q = c.conn;
				if (c.seq == 16'd1) begin
					emit(KIND_CONF, c.seq, 0, c.conn, 0, 0, 0, 0);
					start_timer(REG_RETX);
					start_timer(REG_INACT);
					mode_q = MODE_CONN;
				end
			end
		end else if (c.cmd == CMD_ABORT) begin
			emit(KIND_ABORT, 0, 0, c.conn, 0, 0, 0, 0);
			drop_connection();
		end else if (mode_q == MODE_CONN) begin
			if (c.cmd == CMD_ACK) begin
				start_timer(REG_RETX);
				void'(release_frame(c.seq));
				if (c.seq == final_seq_q) begin
					emit(KIND_DISC, 0, 0, c.conn, 0, 0, 0, 0);
					drop_connection();
				end
			end else begin
				conn_q = c.conn;
				emit(KIND_DATA, c.seq, c.eom, c.conn, c.dest, c.src, c.len, c.pay);
				if (window_n < WIN) begin
					window_q[window_n] = '{seq: c.seq, conn: c.conn, eom: c.eom, len: c.len,
						src: c.src, dest: c.dest, payload: c.pay};
					window_n++;
				end
				if (window_n >= WIN) begin
					mode_q = MODE_BREAK;
					start_timer(REG_RETX);
					emit(KIND_BREAK, 0, 0, c.conn, 0, 0, 0, 0);
				end else begin
					emit(KIND_CONF, c.seq, 0, c.conn, 0, 0, 0, 0);
				end
				start_timer(REG_INACT);
				if (c.eom) final_seq_q = c.seq;
			end
		end else begin
			if (c.cmd == CMD_ACK) begin
				start_timer(REG_RETX);
				start_timer(REG_INACT);
				if (window_n > 0) begin
					newest = window_q[window_n - 1].seq;
					if (release_frame(c.seq) >= 0 && c.seq == newest) begin
						emit(KIND_CONF, c.seq, 0, c.conn, 0, 0, 0, 0);
						mode_q = MODE_CONN;
					end
				end
			end
		end
		n = burst.size();
		k0 = (n > 0) ? burst[0].kind : 3'd7;
		if (n > 0) burst[n - 1].last = 1'b1;
		foreach (burst[i]) expected_results.push_back(burst[i]);
	endfunction

	function automatic command_t make_cmd(logic [1:0] cm, logic [15:0] s, logic e,
			logic [15:0] c);
		command_t r;
		r.cmd = cm; r.seq = s; r.eom = e; r.conn = c;
		r.dest = $urandom; r.src = $urandom; r.len = $urandom; r.pay = $urandom;
		return r;
	endfunction

	function automatic command_t noise_cmd();
		return make_cmd($urandom_range(0, 3), $urandom, $urandom_range(0, 1), $urandom);
	endfunction

	// Picks the next command from the predicted mode, mostly well-formed traffic.
	function automatic command_t pick_command();
		int r;
		logic [15:0] c;
		r = $urandom_range(0, 99);
		c = conn_q;
		if (r < 8) return noise_cmd();
		case (mode_q)
			MODE_IDLE: begin
				next_seq = 16'd2;
				return make_cmd(CMD_DATA, $urandom_range(0, 3), 1'b0, $urandom);
			end
			MODE_AWAIT: begin
				if (r < 85) return make_cmd(CMD_ACK, 16'd1, 1'b0, c);
				if (r < 92) return make_cmd(CMD_ACK, $urandom, 1'b0, c);
				return make_cmd(CMD_TICK, 0, 0, 0);
			end
			MODE_CONN: begin
				if (r < 48) begin
					next_seq++;
					return make_cmd(CMD_DATA, next_seq, ($urandom_range(0, 9) == 0), c);
				end
				if (r < 72 && window_n > 0)
					return make_cmd(CMD_ACK, window_q[$urandom_range(0, window_n - 1)].seq, 0, c);
				if (r < 76) return make_cmd(CMD_ACK, final_seq_q, 1'b0, c);
				if (r < 78) return make_cmd(CMD_ABORT, 0, 0, $urandom);
				return make_cmd(CMD_TICK, 0, 0, 0);
			end
			default: begin
				if (r < 55) return make_cmd(CMD_ACK, window_q[window_n - 1].seq, 0, c);
				if (r < 70) return make_cmd(CMD_ACK, window_q[$urandom_range(0, window_n - 1)].seq, 0, c);
				if (r < 74) return make_cmd(CMD_DATA, $urandom, 1'b0, c);
				return make_cmd(CMD_TICK, 0, 0, 0);
			end
		endcase
	endfunction

	// Offers one command from the falling edge on, and predicts once it is taken.
	task automatic send_command(input command_t c, output int n, output logic [2:0] k0);
		int gap;
		gap = $urandom_range(0, 99);
		gap = (gap < 60) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(15, 40);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = c.cmd; seq_num = c.seq; end_of_message = c.eom; conn_id = c.conn;
		dest_address = c.dest; src_address = c.src; payload_len = c.len; payload_word = c.pay;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		predict_sender(c, n, k0);
		commands_sent++;
		@(negedge clk);
	endtask

	// Waits until the sender has gone quiet, so that registers may be written.
	task automatic wait_quiet();
		in_valid = 1'b0;
		wait (expected_results.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	// APB write of a timeout register, followed by a read back.
	task automatic write_timeout(input logic [1:0] idx, input logic [15:0] value);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = value;
		@(negedge clk) penable = 1'b1;
		@(negedge clk);
		timeout_reg[idx] = value;
		psel = 1'b1; penable = 1'b0; pwrite = 1'b0;
		@(negedge clk) penable = 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== value) begin
			$display("%0t: register %0d read back: expected %0d, actual %0d",
				$time, idx, value, prdata[15:0]);
			errors++;
		end
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: result %0d field %s: expected 0x%0h, actual 0x%0h",
				$time, results_seen, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Receiver: stalls in random bursts, with one long hold-off on request.
	initial begin
		int left;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall = 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				hold_request = 1'b0;
			end
			if (left > 0) begin
				left--;
			end else begin
				left = $urandom_range(0, 99);
				if (left < 50) begin
					out_stall = 1'b0; left = $urandom_range(2, 30);
				end else if (left < 95) begin
					out_stall = 1'b1; left = $urandom_range(0, 3);
				end else begin
					out_stall = 1'b1; left = $urandom_range(15, 40);
				end
			end
		end
	end

	// Every result taken is compared with the oldest prediction.
	always @(posedge clk) begin
		indication_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: kind %0d seq %0d conn %0d",
					$time, kind, out_seq, out_conn);
				errors++;
			end else begin
				e = expected_results.pop_front();
				check_field("kind", e.kind, kind);
				check_field("out_seq", e.seq, out_seq);
				check_field("out_eom", e.eom, out_eom);
				check_field("out_conn", e.conn, out_conn);
				check_field("out_dest", e.dest, out_dest);
				check_field("out_src", e.src, out_src);
				check_field("out_len", e.len, out_len);
				check_field("out_payload", e.pay, out_payload);
				check_field("last_of_run", e.last, last_of_run);
				case (e.kind)
					KIND_DATA:  frames_seen++;
					KIND_ABORT: aborts_seen++;
					KIND_DISC:  disc_seen++;
					KIND_BREAK: breaks_seen++;
					default: ;
				endcase
			end
			results_seen++;
		end
	end

	// Watchdog: a long run of cycles without any transaction means a hang.
	always @(posedge clk) begin
		int quiet;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
		else quiet++;
		if (quiet >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus: directed table, then four random phases with different timeouts.
	initial begin
		directed_row_t rows [$];
		command_t      c;
		int            n;
		logic [2:0]    k0;
		logic [15:0]   phase_cfg [4][3];

		sender_reset();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(negedge clk);

		// Idle ignores everything but a data request.
		rows.push_back('{make_cmd(CMD_TICK, 0, 0, 0), 0, 0});
		rows.push_back('{make_cmd(CMD_ACK, 1, 0, 16'h0007), 0, 0});
		// Opening request with every header field at its top value.
		c = make_cmd(CMD_DATA, 16'hFFFF, 1'b1, 16'hFFFF);
		c.dest = 16'hFFFF; c.src = 16'hFFFF; c.len = 10'h3FF; c.pay = 32'hFFFF_FFFF;
		rows.push_back('{c, 1, KIND_DATA});
		// Await-ack ignores requests and aborts; a wrong first ack stops the connect timer.
		rows.push_back('{make_cmd(CMD_DATA, 0, 0, 16'hFFFF), 0, 0});
		rows.push_back('{make_cmd(CMD_ABORT, 0, 0, 16'hFFFF), 0, 0});
		rows.push_back('{make_cmd(CMD_ACK, 16'd2, 0, 16'hFFFF), 0, 0});
		rows.push_back('{make_cmd(CMD_ACK, 16'd1, 0, 16'hFFFF), 1, KIND_CONF});
		// Fill the window; the fifth request breaks, an end-of-message sets the final sequence.
		for (int i = 0; i < 5; i++) begin
			c = make_cmd(CMD_DATA, 16'd10 + i, (i == 2), 16'hFFFF);
			if (i == 0) begin
				c.dest = 0; c.src = 0; c.len = 0; c.pay = 0;
			end
			rows.push_back('{c, 2, KIND_DATA});
		end
		rows.push_back('{make_cmd(CMD_DATA, 16'd40, 0, 16'hFFFF), 0, 0});
		rows.push_back('{make_cmd(CMD_ACK, 16'd99, 0, 16'hFFFF), 0, 0});
		rows.push_back('{make_cmd(CMD_ACK, 16'd14, 0, 16'hFFFF), 1, KIND_CONF});
		// Five ticks: the retransmit timer resends all kept frames, oldest first.
		for (int i = 0; i < 5; i++) rows.push_back('{make_cmd(CMD_TICK, 0, 0, 0), -1, 0});
		rows.push_back('{make_cmd(CMD_ACK, 16'd50, 0, 16'hFFFF), 0, 0});
		rows.push_back('{make_cmd(CMD_ACK, 16'd12, 0, 16'hFFFF), 1, KIND_DISC});
		// New connection left to time out: an empty resend, then inactivity beats retransmit.
		rows.push_back('{make_cmd(CMD_DATA, 16'd0, 0, 16'h0000), 1, KIND_DATA});
		rows.push_back('{make_cmd(CMD_ACK, 16'd1, 0, 16'h0000), 1, KIND_CONF});
		for (int i = 0; i < 10; i++) rows.push_back('{make_cmd(CMD_TICK, 0, 0, 0), -1, 0});
		// Peer abort while connected.
		rows.push_back('{make_cmd(CMD_DATA, 16'd3, 0, 16'h1234), 1, KIND_DATA});
		rows.push_back('{make_cmd(CMD_ACK, 16'd1, 0, 16'h1234), 1, KIND_CONF});
		rows.push_back('{make_cmd(CMD_ABORT, 0, 0, 16'h4321), 1, KIND_ABORT});

		foreach (rows[i]) begin
			send_command(rows[i].c, n, k0);
			if (rows[i].n_typed >= 0 && (n != rows[i].n_typed ||
					(n > 0 && k0 != rows[i].kind_typed))) begin
				$display("%0t: directed row %0d: expected %0d results of kind %0d, actual %0d of kind %0d",
					$time, i, rows[i].n_typed, rows[i].kind_typed, n, k0);
				errors++;
			end
		end

		// Timeout settings for the random phases: both extremes, a random one and reset values.
		phase_cfg[0] = '{16'd1, 16'd1, 16'd1};
		phase_cfg[1] = '{16'($urandom_range(2, 12)), 16'($urandom_range(2, 8)),
			16'($urandom_range(4, 20))};
		phase_cfg[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
		phase_cfg[3] = '{CONNECT_RESET, RETX_RESET, INACT_RESET};
		for (int p = 0; p < 4; p++) begin
			wait_quiet();
			write_timeout(REG_CONNECT, phase_cfg[p][0]);
			write_timeout(REG_RETX, phase_cfg[p][1]);
			write_timeout(REG_INACT, phase_cfg[p][2]);
			if (p == 1) hold_request = 1'b1;
			for (int i = 0; i < 75; i++) begin
				c = pick_command();
				send_command(c, n, k0);
			end
		end

		in_valid = 1'b0;
		wait (expected_results.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d commands over four timeout settings; checked %0d results",
			commands_sent, results_seen);
		$display("(%0d data frames, %0d breaks, %0d aborts, %0d disconnects)",
			frames_seen, breaks_seen, aborts_seen, disc_seen);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
